FILE: design/bli_pkg.sv
// Package for the bounded list block: operation codes, cell select word,
// sequencer state encoding. No dependencies.
package bli_pkg;

	localparam int DEPTH_DEFAULT = 32;
	localparam int DATA_W        = 32;
	localparam int POS_W         = 5;

	localparam logic [1:0] OP_HEAD   = 2'd0;
	localparam logic [1:0] OP_TAIL   = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// Where a cell takes its next value from; all low means hold.
	typedef struct packed {
		logic take_new;
		logic take_left;
		logic take_right;
		logic take_wrap;
	} cell_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

endpackage

FILE: design/bli_cell.sv
// One storage cell of the bounded list chain.
// Depends on bli_pkg for the select word.
module bli_cell (
	input  logic                          clk,
	input  bli_pkg::cell_sel_t            sel,
	input  logic [bli_pkg::DATA_W-1:0]    new_value,
	input  logic [bli_pkg::DATA_W-1:0]    left_value,
	input  logic [bli_pkg::DATA_W-1:0]    right_value,
	input  logic [bli_pkg::DATA_W-1:0]    wrap_value,
	output logic [bli_pkg::DATA_W-1:0]    value
);
	import bli_pkg::*;

	logic [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (sel.take_new) begin
			value_q <= new_value;
		end else if (sel.take_left) begin
			value_q <= left_value;
		end else if (sel.take_right) begin
			value_q <= right_value;
		end else if (sel.take_wrap) begin
			value_q <= wrap_value;
		end
	end

	assign value = value_q;

endmodule

FILE: design/bounded_list_insert_delete_top.sv
// Top level of the bounded list block: sequencer, element count and the
// chain of bli_cell storage cells. Depends on bli_pkg and bli_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per operation:
//   operation (head insert, tail append, delete at position), value and
//   position. Output channel (out_valid / out_stall) carries the list dump
//   that follows every operation, head first, one word per element, with
//   last_element on the final word. An empty list yields one word with
//   list_empty and last_element set. insert_dropped marks every word of a
//   dump whose insert found the list full.
//   Accepting the input word moves the sequencer to its dump state, from
//   which each dump word is registered into the output register. The dump
//   walks the cell chain one element per cycle while out_stall is low, for
//   max(count,1) words, where count is the list length after the operation.
//   in_stall is high for the whole dump, so no new operation is taken then.
//   The list is held as a row of cells; an operation shifts the row as its
//   word is accepted, and the dump rotates the row left once per emitted
//   word, so after count words the row is back in order.
//   Reset clears the count and the sequencer: the list starts empty. Cells
//   hold no reset value. When out_stall is high, hold the output word and
//   freeze the rotation until the word is taken.
module bounded_list_insert_delete_top #(
	parameter int DEPTH = bli_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         operation,
	input  logic signed [bli_pkg::DATA_W-1:0]  value,
	input  logic [bli_pkg::POS_W-1:0]          position,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [bli_pkg::DATA_W-1:0]  element,
	output logic                               last_element,
	output logic                               list_empty,
	output logic                               insert_dropped
);
	import bli_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  emit_idx_q;
	logic [CNT_W-1:0]  emit_next;
	logic              dropped_q;

	logic [DATA_W-1:0] element_q;
	logic              out_valid_q;
	logic              last_q;
	logic              empty_q;
	logic              out_drop_q;

	logic              accept;
	logic              emit;
	logic              is_full;
	logic              del_ok;
	logic              do_head;
	logic              do_tail;
	logic              do_del;
	logic              do_rot;
	logic              dump_last;

	logic [DATA_W-1:0] cell_value [DEPTH];

	assign accept  = in_valid && (state_q == ST_IDLE);
	assign emit    = (state_q == ST_DUMP) && (!out_valid_q || !out_stall);
	assign is_full = (count_q == FULL_CNT);
	assign del_ok  = CMP_W'(position) < CMP_W'(count_q);

	assign do_head = accept && (operation == OP_HEAD) && !is_full;
	assign do_tail = accept && (operation == OP_TAIL) && !is_full;
	assign do_del  = accept && (operation == OP_DELETE) && del_ok;
	// Rotate the row on every dump word of a non-empty list.
	assign do_rot  = emit && (count_q != '0);

	assign emit_next = emit_idx_q + 1'b1;
	assign dump_last = (count_q == '0) || (emit_next == count_q);

	// Cell chain: each cell picks its source from the broadcast command.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] I_C  = CNT_W'(i);
		localparam logic [CNT_W-1:0] I_P1 = CNT_W'(i + 1);

		cell_sel_t         sel;
		logic [DATA_W-1:0] left_v;
		logic [DATA_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = cell_value[0];
		end else begin : g_mid_l
			assign left_v = cell_value[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = cell_value[i];
		end else begin : g_mid_r
			assign right_v = cell_value[i+1];
		end

		always_comb begin
			sel            = '0;
			sel.take_new   = (do_head && (i == 0)) || (do_tail && (count_q == I_C));
			sel.take_left  = do_head && (i != 0);
			sel.take_right = (do_del && (CMP_W'(I_C) >= CMP_W'(position)))
				|| (do_rot && (count_q != I_P1));
			sel.take_wrap  = do_rot && (count_q == I_P1);
		end

		bli_cell u_cell (
			.clk         (clk),
			.sel         (sel),
			.new_value   (value),
			.left_value  (left_v),
			.right_value (right_v),
			.wrap_value  (cell_value[0]),
			.value       (cell_value[i])
		);
	end

	// Sequencer and element count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			emit_idx_q <= '0;
			dropped_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_DUMP;
						emit_idx_q <= '0;
						dropped_q  <= (operation == OP_HEAD || operation == OP_TAIL)
							&& is_full;
						if (do_head || do_tail) begin
							count_q <= count_q + 1'b1;
						end else if (do_del) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				ST_DUMP: begin
					if (emit) begin
						if (dump_last) begin
							state_q    <= ST_IDLE;
							emit_idx_q <= '0;
						end else begin
							emit_idx_q <= emit_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: advance on emit, drop valid once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			element_q  <= (count_q == '0) ? '0 : cell_value[0];
			last_q     <= dump_last;
			empty_q    <= (count_q == '0);
			out_drop_q <= dropped_q;
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign element        = element_q;
	assign last_element   = last_q;
	assign list_empty     = empty_q;
	assign insert_dropped = out_drop_q;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the bounded list block: queue-fed driver,
// dump monitor and a list predictor of its own. Depends on bli_pkg and
// bounded_list_insert_delete_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bli_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int N_RANDOM    = 250;
	localparam int LIMIT       = 500000;
	localparam int TAIL_CYCLES = 2 * DEPTH + 10;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int CALM_FROM   = 3000;
	localparam int CALM_TO     = 6000;

	// Code 3 is not an operation: the block only dumps the list.
	localparam logic [1:0] OP_NONE = 2'd3;

	// One input word as queued for the driver.
	typedef struct {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		logic                     drain;
	} list_op_t;

	// One expected word of a list dump.
	typedef struct {
		logic signed [DATA_W-1:0] element;
		logic                     last;
		logic                     empty;
		logic                     dropped;
	} dump_word_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic                     in_stall;
	logic [1:0]               operation      = OP_HEAD;
	logic signed [DATA_W-1:0] value          = '0;
	logic [POS_W-1:0]         position       = '0;
	logic                     out_valid;
	logic                     out_stall      = 1'b0;
	logic signed [DATA_W-1:0] element;
	logic                     last_element;
	logic                     list_empty;
	logic                     insert_dropped;

	list_op_t   pending_ops[$];
	dump_word_t dump_q[$];

	// Predictor state: the list as it should stand after every accepted word.
	logic signed [DATA_W-1:0] list_model[DEPTH];
	int                       model_count = 0;

	// Shadow count the generator uses to shape well-formed sequences.
	int gen_count = 0;

	int  cyc             = 0;
	int  errors          = 0;
	int  items_taken     = 0;
	int  words_predicted = 0;
	int  words_checked   = 0;
	int  hold_left       = 0;
	bit  hold_done       = 1'b0;
	bit  took;
	list_op_t   cur_op;
	dump_word_t exp_word;

	wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	bounded_list_insert_delete_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.value          (value),
		.position       (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.element        (element),
		.last_element   (last_element),
		.list_empty     (list_empty),
		.insert_dropped (insert_dropped)
	);

	always #5 clk = ~clk;

	// Apply one operation to the model list and queue the dump it causes.
	task automatic apply_list_op(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos);
		logic       dropped;
		dump_word_t w;
		int         i;
		dropped = 1'b0;
		case (op)
			OP_HEAD, OP_TAIL: begin
				if (model_count >= DEPTH) begin
					// Full list: refuse the insert and flag the whole dump.
					dropped = 1'b1;
				end else if (op == OP_HEAD) begin
					for (i = model_count; i > 0; i--)
						list_model[i] = list_model[i - 1];
					list_model[0] = val;
					model_count++;
				end else begin
					list_model[model_count] = val;
					model_count++;
				end
			end
			OP_DELETE: begin
				// Drop deletes at or beyond the count, on an empty list too.
				if (int'(pos) < model_count) begin
					for (i = int'(pos); i + 1 < model_count; i++)
						list_model[i] = list_model[i + 1];
					model_count--;
				end
			end
			default: begin
			end
		endcase
		if (model_count == 0) begin
			w.element = '0;
			w.last    = 1'b1;
			w.empty   = 1'b1;
			w.dropped = dropped;
			dump_q.push_back(w);
		end else begin
			for (i = 0; i < model_count; i++) begin
				w.element = list_model[i];
				w.last    = (i + 1 == model_count);
				w.empty   = 1'b0;
				w.dropped = dropped;
				dump_q.push_back(w);
			end
		end
	endtask

	// Queue one word for the driver and advance the generator's shadow count.
	task automatic push_op(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos, input logic drain);
		list_op_t o;
		o.op    = op;
		o.val   = val;
		o.pos   = pos;
		o.drain = drain;
		pending_ops.push_back(o);
		if ((op == OP_HEAD || op == OP_TAIL) && gen_count < DEPTH)
			gen_count++;
		else if (op == OP_DELETE && int'(pos) < gen_count)
			gen_count--;
	endtask

	// Favor the sign and range extremes, otherwise any 32-bit pattern.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: pick_value = 32'sh8000_0000;
			1: pick_value = 32'sh7fff_ffff;
			2: pick_value = '0;
			3: pick_value = -1;
			default: pick_value = $urandom;
		endcase
	endfunction

	// Cycle count and timeout; update by nonblocking so every process
	// sees the same count at an edge.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Driver: predict on every accepted word, then offer the next one.
	// Hold the payload while stalled; idle at random outside the calm window,
	// and hold back a drain-marked word until every dump word has come.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= OP_HEAD;
			value     <= '0;
			position  <= '0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				apply_list_op(operation, value, position);
				items_taken     <= items_taken + 1;
				words_predicted <= words_predicted + (model_count == 0 ? 1 : model_count);
			end
			if (!in_valid || took) begin
				if (pending_ops.size() != 0
						&& !(pending_ops[0].drain && (took || words_predicted != words_checked))
						&& !(!calm && $urandom_range(0, 99) < 33)) begin
					cur_op    = pending_ops.pop_front();
					operation <= cur_op.op;
					value     <= cur_op.val;
					position  <= cur_op.pos;
					in_valid  <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver: check each taken dump word against the oldest
	// expectation, then pick the stall for the next cycle. Once, midway,
	// hold off for a long stretch so the sender backs up against in_stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_checked <= words_checked + 1;
				if (dump_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: element %0d last %0b empty %0b dropped %0b",
						$time, element, last_element, list_empty, insert_dropped);
				end else begin
					exp_word = dump_q.pop_front();
					// Element carries nothing on an empty dump; skip it there.
					if (!exp_word.empty && element !== exp_word.element) begin
						errors++;
						$display("%0t: element mismatch: expected %0d, actual %0d",
							$time, exp_word.element, element);
					end
					if (last_element !== exp_word.last) begin
						errors++;
						$display("%0t: last_element mismatch: expected %0b, actual %0b",
							$time, exp_word.last, last_element);
					end
					if (list_empty !== exp_word.empty) begin
						errors++;
						$display("%0t: list_empty mismatch: expected %0b, actual %0b",
							$time, exp_word.empty, list_empty);
					end
					if (insert_dropped !== exp_word.dropped) begin
						errors++;
						$display("%0t: insert_dropped mismatch: expected %0b, actual %0b",
							$time, exp_word.dropped, insert_dropped);
					end
				end
			end
			if (!hold_done && items_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 33);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int made;
		int mode;
		int r;
		logic [1:0] ins_op;

		// Directed: empty-list deletes and no-op, value extremes at both ends,
		// deletes at tail, head, middle and beyond the count.
		push_op(OP_DELETE, 32'sd0, 5'd0, 1'b0);
		push_op(OP_DELETE, 32'sd0, 5'd31, 1'b0);
		push_op(OP_NONE, -1, 5'd31, 1'b0);
		push_op(OP_HEAD, 32'sh7fff_ffff, 5'd0, 1'b0);
		push_op(OP_HEAD, 32'sh8000_0000, 5'd31, 1'b0);
		push_op(OP_TAIL, 32'sd0, 5'd0, 1'b0);
		push_op(OP_TAIL, -1, 5'd0, 1'b0);
		push_op(OP_HEAD, 32'sh5555_5555, 5'd0, 1'b0);
		push_op(OP_TAIL, 32'shaaaa_aaaa, 5'd0, 1'b0);
		push_op(OP_DELETE, 32'sd0, 5'd6, 1'b0);
		push_op(OP_DELETE, 32'sd0, 5'd5, 1'b0);
		push_op(OP_DELETE, 32'sd0, 5'd0, 1'b0);
		push_op(OP_DELETE, 32'sd0, 5'd1, 1'b0);
		push_op(OP_NONE, 32'sd0, 5'd0, 1'b0);
		push_op(OP_DELETE, -1, 5'd31, 1'b0);

		// Random: alternate fill and drain runs so the list keeps hitting full
		// (dropped inserts) and empty, with some noise mixed in. Noise words
		// do not count toward the total.
		made = 0;
		mode = 0;
		while (made < N_RANDOM) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				if (r < 5 || gen_count >= DEPTH)
					push_op(OP_NONE, pick_value(), POS_W'($urandom), 1'b0);
				else
					push_op(OP_DELETE, pick_value(),
						POS_W'($urandom_range(gen_count, 2**POS_W - 1)), 1'b0);
			end else begin
				ins_op = $urandom_range(0, 1) ? OP_TAIL : OP_HEAD;
				r = $urandom_range(0, 99);
				if (((mode == 0) ? (r < 85) : (r >= 85)) || gen_count == 0)
					push_op(ins_op, pick_value(), POS_W'($urandom), made == 0);
				else
					push_op(OP_DELETE, pick_value(),
						POS_W'($urandom_range(0, gen_count - 1)), made == 0);
				if (mode == 0 && gen_count == DEPTH && $urandom_range(0, 2) == 0)
					mode = 1;
				else if (mode == 1 && gen_count <= $urandom_range(0, 2))
					mode = 0;
				// Now and then pause the sender until the dump has drained.
				if ($urandom_range(0, 99) == 0)
					pending_ops[pending_ops.size() - 1].drain = 1'b1;
				made++;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || in_valid)
			@(posedge clk);
		while (dump_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (dump_q.size() != 0) begin
			errors++;
			$display("%0t: %0d dump words never arrived", $time, dump_q.size());
		end
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
design/bli_pkg.sv
design/bli_cell.sv
design/bounded_list_insert_delete_top.sv
tb/sv/testbench.sv
